// File: hdl/xidp_pkg.sv
// ----------------------------------------------------------------------------
// xidp_pkg
// Shared types and constants of the device-scan reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package xidp_pkg;

    localparam int unsigned UID_MAX_DEF = 19;
    localparam int unsigned DESC_DEPTH  = 2;
    localparam int unsigned OUT_DEPTH   = 4;
    localparam int unsigned IDX_W       = 5;

    localparam logic [7:0] FORMAT_BYTE = 8'h81;
    localparam logic [7:0] GROUP_BYTE  = 8'hF0;

    localparam logic [7:0] PID_UID    = 8'd1;
    localparam logic [7:0] PID_TYPE   = 8'd4;
    localparam logic [7:0] PID_VENDOR = 8'd6;

    localparam logic [7:0] CFG_SCAN_ADDR = 8'd0;
    localparam logic [7:0] CFG_XID_CTRL  = 8'd1;

    localparam logic [7:0] SCAN_ADDR_RST = 8'd0;
    localparam logic [7:0] XID_CTRL_RST  = 8'd191;

    typedef struct packed {
        logic        accepted;
        logic        bank;
        logic [7:0]  len;
        logic [7:0]  dev_type;
        logic [15:0] vendor;
    } t_desc;

    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] pos;
        logic [7:0] data;
    } t_uid_wr;

    typedef struct packed {
        logic             accepted;
        logic [7:0]       uid_byte;
        logic [IDX_W-1:0] uid_index;
        logic [IDX_W-1:0] uid_length;
        logic [7:0]       device_type;
        logic [15:0]      vendor_code;
        logic             last_of_run;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/xid_scan_response_parser_top.sv
// ----------------------------------------------------------------------------
// xid_scan_response_parser_top
// Device-scan reply parser: one information byte per cycle in, a run of
// unique-id results (or one reject) out per frame.
// ----------------------------------------------------------------------------
// Takes one byte per clock while full is low. full rises while the frame
// descriptor queue is full or while both unique-id buffer banks are held by
// runs not yet played out, so a new frame can be parsed while the previous
// run drains. A frame's results pass through the descriptor queue, descriptor
// register, buffer read and output queue and then leave at one per cycle
// while pop is high, a run of uid_length results for an accepted frame and
// a single result for a rejected one. There is no clearing pass after reset.
`default_nettype none

module xid_scan_response_parser_top #(
    parameter int unsigned UID_MAX = xidp_pkg::UID_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_empty_info,
    input  wire logic [7:0]  i_frame_address,
    input  wire logic [7:0]  i_frame_control,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_accepted,
    output logic [7:0]       o_uid_byte,
    output logic [4:0]       o_uid_index,
    output logic [4:0]       o_uid_length,
    output logic [7:0]       o_device_type,
    output logic [15:0]      o_vendor_code,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    xidp_pkg::t_desc   w_desc_in, w_desc_out;
    xidp_pkg::t_uid_wr w_uid_wr;
    xidp_pkg::t_result w_result;
    logic              w_desc_push, w_desc_full, w_desc_empty, w_desc_pop;
    logic              w_bank_release;

    assign o_cfg_ready = 1'b1;

    xidp_front #(
        .UID_MAX (UID_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_empty_info    (i_empty_info),
        .i_frame_address (i_frame_address),
        .i_frame_control (i_frame_control),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_desc_push     (w_desc_push),
        .o_desc          (w_desc_in),
        .i_desc_full     (w_desc_full),
        .o_uid_wr        (w_uid_wr),
        .i_bank_release  (w_bank_release)
    );

    xidp_fifo #(
        .W     ($bits(xidp_pkg::t_desc)),
        .DEPTH (xidp_pkg::DESC_DEPTH)
    ) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_desc_push),
        .i_wdata (w_desc_in),
        .o_full  (w_desc_full),
        .i_pop   (w_desc_pop),
        .o_rdata (w_desc_out),
        .o_empty (w_desc_empty),
        .o_count ()
    );

    xidp_back #(
        .UID_MAX (UID_MAX)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uid_wr       (w_uid_wr),
        .i_desc         (w_desc_out),
        .i_desc_empty   (w_desc_empty),
        .o_desc_pop     (w_desc_pop),
        .o_bank_release (w_bank_release),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_result       (w_result)
    );

    assign o_accepted    = w_result.accepted;
    assign o_uid_byte    = w_result.uid_byte;
    assign o_uid_index   = w_result.uid_index;
    assign o_uid_length  = w_result.uid_length;
    assign o_device_type = w_result.device_type;
    assign o_vendor_code = w_result.vendor_code;
    assign o_last_of_run = w_result.last_of_run;

endmodule

`default_nettype wire

// File: hdl/xidp_fifo.sv
// ----------------------------------------------------------------------------
// xidp_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module xidp_fifo #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [W-1:0]               i_wdata,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic [W-1:0]                    o_rdata,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (w_push) begin
            n_wp = (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + PW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + PW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// File: hdl/xidp_front.sv
// ----------------------------------------------------------------------------
// xidp_front
// Byte parser: walks format, group and parameters, captures fields, and
// issues one frame descriptor with the verdict at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module xidp_front #(
    parameter int unsigned UID_MAX = xidp_pkg::UID_MAX_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_last_byte,
    input  wire logic             i_empty_info,
    input  wire logic [7:0]       i_frame_address,
    input  wire logic [7:0]       i_frame_control,
    input  wire logic             i_cfg_valid,
    input  wire logic [7:0]       i_cfg_index,
    input  wire logic [7:0]       i_cfg_data,
    output logic                  o_desc_push,
    output xidp_pkg::t_desc       o_desc,
    input  wire logic             i_desc_full,
    output xidp_pkg::t_uid_wr     o_uid_wr,
    input  wire logic             i_bank_release
);

    typedef enum logic [2:0] {
        PH_FORMAT,
        PH_GROUP,
        PH_GLEN,
        PH_PID,
        PH_PLEN,
        PH_VALUE,
        PH_ERROR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_glen, n_glen;
    logic [8:0]  r_bcnt, n_bcnt;
    logic [7:0]  r_pid, n_pid;
    logic [7:0]  r_vrem, n_vrem;
    logic [7:0]  r_vpos, n_vpos;
    logic [2:0]  r_found, n_found;
    logic [7:0]  r_uid_len, n_uid_len;
    logic [7:0]  r_type_len, n_type_len;
    logic [7:0]  r_vend_len, n_vend_len;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_vend, n_vend;
    logic [7:0]  r_uid0, n_uid0;
    logic [7:0]  r_uid1, n_uid1;
    logic        r_wbank, n_wbank;
    logic [1:0]  r_busy, n_busy;
    logic [7:0]  r_scan_addr, r_xid_ctrl;
    logic        w_accept, w_valid, w_end, w_inc;

    assign o_full   = i_desc_full || (r_busy == 2'd2);
    assign w_accept = i_push && !o_full;
    assign w_end    = w_accept && (i_empty_info || i_last_byte);

    always_comb begin
        n_phase    = r_phase;
        n_glen     = r_glen;
        n_bcnt     = r_bcnt;
        n_pid      = r_pid;
        n_vrem     = r_vrem;
        n_vpos     = r_vpos;
        n_found    = r_found;
        n_uid_len  = r_uid_len;
        n_type_len = r_type_len;
        n_vend_len = r_vend_len;
        n_type     = r_type;
        n_vend     = r_vend;
        n_uid0     = r_uid0;
        n_uid1     = r_uid1;
        n_wbank    = r_wbank;
        w_inc      = 1'b0;
        o_uid_wr   = '{en: 1'b0, bank: r_wbank, pos: r_vpos, data: i_data_byte};
        o_desc     = '0;
        o_desc_push = 1'b0;

        if (w_accept && !i_empty_info) begin
            if ((r_phase == PH_PID) || (r_phase == PH_PLEN) || (r_phase == PH_VALUE)) begin
                n_bcnt = (r_bcnt == 9'd511) ? r_bcnt : r_bcnt + 9'd1;
            end
            case (r_phase)
                PH_FORMAT: begin
                    n_phase = (i_data_byte == xidp_pkg::FORMAT_BYTE) ? PH_GROUP : PH_ERROR;
                end
                PH_GROUP: begin
                    n_phase = (i_data_byte == xidp_pkg::GROUP_BYTE) ? PH_GLEN : PH_ERROR;
                end
                PH_GLEN: begin
                    n_glen  = i_data_byte;
                    n_phase = PH_PID;
                end
                PH_PID: begin
                    n_pid   = i_data_byte;
                    n_phase = PH_PLEN;
                end
                PH_PLEN: begin
                    if (r_pid == xidp_pkg::PID_UID && !r_found[0]) begin
                        n_found[0] = 1'b1;
                        n_uid_len  = i_data_byte;
                    end else if (r_pid == xidp_pkg::PID_TYPE && !r_found[1]) begin
                        n_found[1] = 1'b1;
                        n_type_len = i_data_byte;
                    end else if (r_pid == xidp_pkg::PID_VENDOR && !r_found[2]) begin
                        n_found[2] = 1'b1;
                        n_vend_len = i_data_byte;
                    end else begin
                        n_pid = '0;
                    end
                    n_vrem  = i_data_byte;
                    n_vpos  = '0;
                    n_phase = (i_data_byte == 8'd0) ? PH_PID : PH_VALUE;
                end
                PH_VALUE: begin
                    if (r_pid == xidp_pkg::PID_UID) begin
                        o_uid_wr.en = (r_vpos < 8'(UID_MAX));
                        if (r_vpos == 8'd0) begin
                            n_uid0 = i_data_byte;
                        end
                        if (r_vpos == 8'd1) begin
                            n_uid1 = i_data_byte;
                        end
                    end else if (r_pid == xidp_pkg::PID_TYPE) begin
                        if (r_vpos == 8'd0) begin
                            n_type = i_data_byte;
                        end
                    end else if (r_pid == xidp_pkg::PID_VENDOR) begin
                        if (r_vpos == 8'd0) begin
                            n_vend[15:8] = i_data_byte;
                        end else if (r_vpos == 8'd1) begin
                            n_vend[7:0] = i_data_byte;
                        end
                    end
                    n_vpos = r_vpos + 8'd1;
                    n_vrem = r_vrem - 8'd1;
                    if (n_vrem == 8'd0) begin
                        n_phase = PH_PID;
                    end
                end
                default: begin
                end
            endcase
        end

        w_valid = !i_empty_info
               && (i_frame_address == r_scan_addr)
               && (i_frame_control == r_xid_ctrl)
               && (n_phase == PH_PID)
               && (n_bcnt == {1'b0, n_glen})
               && (n_found == 3'b111)
               && (n_uid_len >= 8'd3)
               && (n_uid_len <= 8'(UID_MAX))
               && (n_type_len == 8'd1)
               && (n_vend_len == 8'd2)
               && (n_uid0 == n_vend[15:8])
               && (n_uid1 == n_vend[7:0]);

        if (w_end) begin
            o_desc_push = 1'b1;
            if (w_valid) begin
                o_desc = '{accepted: 1'b1, bank: r_wbank, len: n_uid_len,
                           dev_type: n_type, vendor: n_vend};
                n_wbank = !r_wbank;
                w_inc   = 1'b1;
            end
            n_phase    = PH_FORMAT;
            n_glen     = '0;
            n_bcnt     = '0;
            n_pid      = '0;
            n_vrem     = '0;
            n_vpos     = '0;
            n_found    = '0;
            n_uid_len  = '0;
            n_type_len = '0;
            n_vend_len = '0;
            n_type     = '0;
            n_vend     = '0;
        end

        case ({w_inc, i_bank_release})
            2'b10:   n_busy = r_busy + 2'd1;
            2'b01:   n_busy = r_busy - 2'd1;
            default: n_busy = r_busy;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FORMAT;
            r_glen      <= '0;
            r_bcnt      <= '0;
            r_pid       <= '0;
            r_vrem      <= '0;
            r_vpos      <= '0;
            r_found     <= '0;
            r_uid_len   <= '0;
            r_type_len  <= '0;
            r_vend_len  <= '0;
            r_type      <= '0;
            r_vend      <= '0;
            r_uid0      <= '0;
            r_uid1      <= '0;
            r_wbank     <= 1'b0;
            r_busy      <= '0;
            r_scan_addr <= xidp_pkg::SCAN_ADDR_RST;
            r_xid_ctrl  <= xidp_pkg::XID_CTRL_RST;
        end else begin
            r_phase    <= n_phase;
            r_glen     <= n_glen;
            r_bcnt     <= n_bcnt;
            r_pid      <= n_pid;
            r_vrem     <= n_vrem;
            r_vpos     <= n_vpos;
            r_found    <= n_found;
            r_uid_len  <= n_uid_len;
            r_type_len <= n_type_len;
            r_vend_len <= n_vend_len;
            r_type     <= n_type;
            r_vend     <= n_vend;
            r_uid0     <= n_uid0;
            r_uid1     <= n_uid1;
            r_wbank    <= n_wbank;
            r_busy     <= n_busy;
            if (i_cfg_valid && i_cfg_index == xidp_pkg::CFG_SCAN_ADDR) begin
                r_scan_addr <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == xidp_pkg::CFG_XID_CTRL) begin
                r_xid_ctrl <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/xidp_back.sv
// ----------------------------------------------------------------------------
// xidp_back
// Result sequencer: holds the banked unique-id buffer and plays each frame
// descriptor out as a run of results into the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xidp_back #(
    parameter int unsigned UID_MAX = xidp_pkg::UID_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire xidp_pkg::t_uid_wr    i_uid_wr,
    input  wire xidp_pkg::t_desc      i_desc,
    input  wire logic                 i_desc_empty,
    output logic                      o_desc_pop,
    output logic                      o_bank_release,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output xidp_pkg::t_result         o_result
);

    localparam int unsigned AW = $clog2(UID_MAX);
    localparam int unsigned LW = $clog2(UID_MAX + 1);
    localparam int unsigned CW = $clog2(xidp_pkg::OUT_DEPTH + 1);

    logic [7:0]          r_mem [2][UID_MAX];
    logic [7:0]          r_rd;
    logic                r_act;
    xidp_pkg::t_desc     r_desc;
    logic [LW-1:0]       r_k;
    logic                r_s1_valid;
    xidp_pkg::t_result   r_s1;
    xidp_pkg::t_result   w_out;
    logic [CW-1:0]       w_out_count;
    logic                w_out_full;
    logic                w_issue, w_k_last;

    assign o_desc_pop     = !r_act && !i_desc_empty;
    assign w_issue        = r_act
                         && (({1'b0, w_out_count} + (CW+1)'(r_s1_valid))
                             < (CW+1)'(xidp_pkg::OUT_DEPTH));
    assign w_k_last       = !r_desc.accepted || ((r_k + LW'(1)) == LW'(r_desc.len));
    assign o_bank_release = w_issue && w_k_last && r_desc.accepted;

    always_comb begin
        w_out          = r_s1;
        w_out.uid_byte = r_s1.accepted ? r_rd : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_k        <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
            if (o_desc_pop) begin
                r_act <= 1'b1;
                r_k   <= '0;
            end else if (w_issue) begin
                if (w_k_last) begin
                    r_act <= 1'b0;
                end else begin
                    r_k <= r_k + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_desc <= i_desc;
        end
        if (w_issue) begin
            r_s1.accepted    <= r_desc.accepted;
            r_s1.uid_byte    <= '0;
            r_s1.uid_index   <= xidp_pkg::IDX_W'(r_k);
            r_s1.uid_length  <= r_desc.len[xidp_pkg::IDX_W-1:0];
            r_s1.device_type <= r_desc.dev_type;
            r_s1.vendor_code <= r_desc.vendor;
            r_s1.last_of_run <= w_k_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uid_wr.en) begin
            r_mem[i_uid_wr.bank][i_uid_wr.pos[AW-1:0]] <= i_uid_wr.data;
        end
        if (w_issue) begin
            r_rd <= r_mem[r_desc.bank][r_k[AW-1:0]];
        end
    end

    xidp_fifo #(
        .W     ($bits(xidp_pkg::t_result)),
        .DEPTH (xidp_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_wdata (w_out),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_rdata (o_result),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    logic w_unused_full;
    assign w_unused_full = w_out_full;

endmodule

`default_nettype wire

// File: hdl/xidp_checker.sv
// ----------------------------------------------------------------------------
// xidp_checker
// Port-level checks on the result side of the scan reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

module xidp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic        o_accepted,
    input  wire logic [7:0]  o_uid_byte,
    input  wire logic [4:0]  o_uid_index,
    input  wire logic [4:0]  o_uid_length,
    input  wire logic [15:0] o_vendor_code,
    input  wire logic        o_last_of_run
);

    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_accepted) |->
            (o_last_of_run && o_uid_length == 5'd0 && o_uid_byte == 8'd0
             && o_uid_index == 5'd0 && o_vendor_code == 16'd0))
        else $error("reject result not a single cleared transaction");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_accepted) |->
            (o_last_of_run == ((o_uid_index + 5'd1) == o_uid_length)))
        else $error("last_of_run does not match index and length");

    a_vendor_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_accepted && o_uid_index == 5'd0) |->
            (o_uid_byte == o_vendor_code[15:8]))
        else $error("first unique-id byte differs from vendor code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_uid_byte) && $stable(o_accepted)
             && $stable(o_uid_index)))
        else $error("stalled result transaction changed");

endmodule

bind xid_scan_response_parser_top xidp_checker u_xidp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_accepted    (o_accepted),
    .o_uid_byte    (o_uid_byte),
    .o_uid_index   (o_uid_index),
    .o_uid_length  (o_uid_length),
    .o_vendor_code (o_vendor_code),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire
